>>> src/gcda_pkg.sv
// Shared constants and the CORDIC arctangent table for the great-circle block.
package gcda_pkg;

   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

   function automatic logic signed [33:0] atan_q30(input int idx);
      case (idx)
         0:       return 34'sh3243F6A8;
         1:       return 34'sh1DAC6705;
         2:       return 34'sh0FADBAFC;
         3:       return 34'sh07F56EA6;
         4:       return 34'sh03FEAB76;
         5:       return 34'sh01FFD55B;
         6:       return 34'sh00FFFAAA;
         7:       return 34'sh007FFF55;
         8:       return 34'sh003FFFEA;
         9:       return 34'sh001FFFFD;
         10:      return 34'sh000FFFFF;
         11:      return 34'sh0007FFFF;
         12:      return 34'sh0003FFFF;
         13:      return 34'sh0001FFFF;
         14:      return 34'sh0000FFFF;
         15:      return 34'sh00007FFF;
         16:      return 34'sh00003FFF;
         17:      return 34'sh00001FFF;
         18:      return 34'sh00000FFF;
         19:      return 34'sh000007FF;
         20:      return 34'sh000003FF;
         21:      return 34'sh000001FF;
         22:      return 34'sh000000FF;
         23:      return 34'sh0000007F;
         24:      return 34'sh0000003F;
         25:      return 34'sh0000001F;
         26:      return 34'sh0000000F;
         27:      return 34'sh00000008;
         28:      return 34'sh00000004;
         29:      return 34'sh00000002;
         30:      return 34'sh00000001;
         default: return 34'sh0;
      endcase
   endfunction

endpackage

>>> src/gcda_delay.sv
// Enabled shift register that keeps side data in step with the main pipeline.
module gcda_delay #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int k = 1; k < DEPTH; k++) begin
            tap_ff[k] <= tap_ff[k-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

>>> src/gcda_sincos.sv
// Angle reduction, degree-to-radian scaling and pipelined rotation CORDIC for sine and cosine.
module gcda_sincos import gcda_pkg::*; #(
   parameter int STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [25:0] deg,
   output logic               out_valid,
   output logic signed [31:0] sin_q,
   output logic signed [31:0] cos_q
);

   localparam logic signed [27:0] FULL   = 28'sd23592960;
   localparam logic signed [27:0] FULL2  = 28'sd47185920;
   localparam logic signed [27:0] HALF_W = 28'sd11796480;
   localparam logic signed [24:0] HALF   = 25'sd11796480;
   localparam logic signed [24:0] QUART  = 25'sd5898240;
   localparam logic [17:0] RAD_LO = 18'd108693;
   localparam logic [16:0] RAD_HI = 17'd73204;
   localparam logic signed [33:0] GAIN = 34'sd652032874;

   logic signed [27:0] d_ext, r0, r1;
   logic signed [24:0] ra_in, ra_ff, rb;
   logic               va_ff, vb_ff, vc_ff;
   logic [22:0]        mag_in, mag_ff;
   logic               neg_in, neg_ff, flip_in, flip_ff, negc_ff, flipc_ff;
   logic [40:0]        plo_in, plo_ff;
   logic [39:0]        phi_in, phi_ff;
   logic [57:0]        sum;
   logic signed [33:0] z_in;

   logic signed [33:0] cx_ff [0:STEPS];
   logic signed [33:0] cy_ff [0:STEPS];
   logic signed [33:0] cz_ff [0:STEPS];
   logic               cf_ff [0:STEPS];
   logic               cv_ff [0:STEPS];
   logic               ov_ff;
   logic signed [31:0] s_ff, c_ff;

   always_comb begin
      d_ext = 28'(deg);
      if (d_ext < 0) begin
         if (d_ext + FULL < 0) begin
            r0 = d_ext + FULL2;
         end else begin
            r0 = d_ext + FULL;
         end
      end else if (d_ext >= FULL) begin
         r0 = d_ext - FULL;
      end else begin
         r0 = d_ext;
      end
      r1 = (r0 >= HALF_W) ? r0 - FULL : r0;
      ra_in = 25'(r1);
   end

   always_comb begin
      flip_in = 1'b0;
      rb = ra_ff;
      if (ra_ff > QUART) begin
         rb = ra_ff - HALF;
         flip_in = 1'b1;
      end else if (ra_ff < -QUART) begin
         rb = ra_ff + HALF;
         flip_in = 1'b1;
      end
      neg_in = rb < 0;
      mag_in = neg_in ? 23'(-rb) : 23'(rb);
   end

   always_comb begin
      plo_in = 41'(mag_ff) * 41'(RAD_LO);
      phi_in = 40'(mag_ff) * 40'(RAD_HI);
   end

   always_comb begin
      sum = 58'(plo_ff) + (58'(phi_ff) << 18) + 58'd33554432;
      z_in = negc_ff ? -$signed(34'(sum[56:26])) : $signed(34'(sum[56:26]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         cv_ff[0] <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         cv_ff[0] <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ra_ff <= ra_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         flip_ff <= flip_in;
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         negc_ff <= neg_ff;
         flipc_ff <= flip_ff;
         cx_ff[0] <= GAIN;
         cy_ff[0] <= '0;
         cz_ff[0] <= z_in;
         cf_ff[0] <= flipc_ff;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      logic signed [33:0] x_in, y_in, z_next_in;

      always_comb begin
         if (cz_ff[i] >= 0) begin
            x_in = cx_ff[i] - (cy_ff[i] >>> i);
            y_in = cy_ff[i] + (cx_ff[i] >>> i);
            z_next_in = cz_ff[i] - atan_q30(i);
         end else begin
            x_in = cx_ff[i] + (cy_ff[i] >>> i);
            y_in = cy_ff[i] - (cx_ff[i] >>> i);
            z_next_in = cz_ff[i] + atan_q30(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[i+1] <= 1'b0;
         end else if (en) begin
            cv_ff[i+1] <= cv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[i+1] <= x_in;
            cy_ff[i+1] <= y_in;
            cz_ff[i+1] <= z_next_in;
            cf_ff[i+1] <= cf_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= cv_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= cf_ff[STEPS] ? 32'(-cy_ff[STEPS]) : 32'(cy_ff[STEPS]);
         c_ff <= cf_ff[STEPS] ? 32'(-cx_ff[STEPS]) : 32'(cx_ff[STEPS]);
      end
   end

   assign out_valid = ov_ff;
   assign sin_q = s_ff;
   assign cos_q = c_ff;

endmodule

>>> src/gcda_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module gcda_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [60:0] radicand,
   output logic        out_valid,
   output logic [30:0] root
);

   localparam int NSTAGE = 31;

   logic [61:0] rem_ff [0:NSTAGE-1];
   logic [61:0] res_ff [0:NSTAGE-1];
   logic        v_ff   [0:NSTAGE-1];

   for (genvar k = 0; k < NSTAGE; k++) begin : g_bit
      localparam logic [61:0] BITC = 62'd1 << (60 - 2 * k);
      logic [61:0] rem_src, res_src, trial, rem_in, res_in;
      logic        v_src;

      if (k == 0) begin : g_first
         assign rem_src = 62'(radicand);
         assign res_src = '0;
         assign v_src = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign res_src = res_ff[k-1];
         assign v_src = v_ff[k-1];
      end

      always_comb begin
         trial = res_src + BITC;
         if (rem_src >= trial) begin
            rem_in = rem_src - trial;
            res_in = (res_src >> 1) + BITC;
         end else begin
            rem_in = rem_src;
            res_in = res_src >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
         end
      end
   end

   assign out_valid = v_ff[NSTAGE-1];
   assign root = res_ff[NSTAGE-1][30:0];

endmodule

>>> src/gcda_vec.sv
// Pipelined vectoring CORDIC giving the four-quadrant arctangent of y over x.
module gcda_vec import gcda_pkg::*; #(
   parameter int STEPS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic signed [35:0] y,
   input  logic signed [35:0] x,
   output logic               out_valid,
   output logic signed [33:0] ang
);

   logic signed [35:0] vx_ff [0:STEPS];
   logic signed [35:0] vy_ff [0:STEPS];
   logic signed [33:0] vz_ff [0:STEPS];
   logic               vv_ff [0:STEPS];
   logic signed [35:0] px_in, py_in;
   logic signed [33:0] pz_in;

   always_comb begin
      px_in = x;
      py_in = y;
      pz_in = '0;
      if (x < 0) begin
         if (y >= 0) begin
            px_in = y;
            py_in = -x;
            pz_in = HALF_PI_Q30;
         end else begin
            px_in = -y;
            py_in = x;
            pz_in = -HALF_PI_Q30;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vv_ff[0] <= 1'b0;
      end else if (en) begin
         vv_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff[0] <= px_in;
         vy_ff[0] <= py_in;
         vz_ff[0] <= pz_in;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_vec
      logic signed [35:0] x_in, y_in;
      logic signed [33:0] z_in;

      always_comb begin
         if (vy_ff[i] >= 0) begin
            x_in = vx_ff[i] + (vy_ff[i] >>> i);
            y_in = vy_ff[i] - (vx_ff[i] >>> i);
            z_in = vz_ff[i] + atan_q30(i);
         end else begin
            x_in = vx_ff[i] - (vy_ff[i] >>> i);
            y_in = vy_ff[i] + (vx_ff[i] >>> i);
            z_in = vz_ff[i] - atan_q30(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vv_ff[i+1] <= 1'b0;
         end else if (en) begin
            vv_ff[i+1] <= vv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            vx_ff[i+1] <= x_in;
            vy_ff[i+1] <= y_in;
            vz_ff[i+1] <= z_in;
         end
      end
   end

   assign out_valid = vv_ff[STEPS];
   assign ang = vz_ff[STEPS];

endmodule

>>> src/great_circle_distance_azimuth.sv
// Great-circle distance and azimuth between two points, fully pipelined.
// The depth is set by the two CORDIC chains and the 31-stage square root; one word is accepted
// and one delivered every cycle while the output is not stalled.
// The whole pipeline advances only when the output register is empty or being taken.
// Synchronous reset clears the valid bits; data registers are not reset.
module great_circle_distance_azimuth import gcda_pkg::*; #(
   parameter int CORDIC_STEPS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_lat[23:0], origin_lon[49:24], target_lat[73:50], target_lon[99:74], zeros above.
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance_rad[21:0], azimuth_rad[44:22], zeros above.
   output logic [47:0]  rsp_tdata,
   // degenerate[0].
   output logic         rsp_tuser
);

   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
   localparam logic signed [31:0] DEGEN_TOL = 32'sd32;
   localparam logic signed [33:0] DIST_MAX = 34'sd3294199;
   localparam logic signed [35:0] AZ_MAX = 36'sd6588397;
   localparam logic signed [35:0] TWO_PI = 36'sd6746518852;

   function automatic logic signed [31:0] rnd30(input logic signed [65:0] a);
      logic signed [65:0] s;
      s = (a + 66'sd536870912) >>> 30;
      return s[31:0];
   endfunction

   logic en;
   logic sv0, sv1, sv2, sv3;
   logic signed [31:0] sla, cla, slo, clo, tsla, tcla, tslo, tclo;

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic signed [63:0] pqx_ff, pqy_ff, ptx_ff, pty_ff;
   logic signed [31:0] sla1_ff, cla1_ff, slo1_ff, clo1_ff, tz1_ff;
   logic signed [31:0] qx_ff, qy_ff, tx_ff, ty_ff, sla2_ff, cla2_ff, slo2_ff, clo2_ff, tz2_ff;
   logic signed [63:0] md0_ff, md1_ff, md2_ff, me0_ff, me1_ff, mt0_ff, mt1_ff;
   logic signed [31:0] sla3_ff, cla3_ff, tz3_ff;
   logic signed [31:0] d4_ff, e4_ff, t4_ff, sla4_ff, cla4_ff, tz4_ff;
   logic signed [31:0] dc_in, dc5_ff, e5_ff;
   logic signed [63:0] dd5_ff, mn0_ff, mn1_ff;
   logic [60:0]        rad6_ff;
   logic signed [31:0] nn6_ff, dc6_ff, e6_ff;
   logic               degen_in;

   logic               sq_valid;
   logic [30:0]        sq_root;
   logic [31:0]        dc_d, e_d, nn_d;
   logic [0:0]         degen_d;
   logic               dv, av;
   logic signed [33:0] zd, za;

   logic               ov_ff, degen_ff;
   logic [21:0]        dist_in, dist_ff;
   logic [22:0]        az_in, az_ff;
   logic signed [33:0] dr;
   logic signed [35:0] zw, ar;

   assign en = !ov_ff || rsp_tready;
   assign req_tready = en;

   gcda_sincos #(.STEPS(CORDIC_STEPS)) u_olat (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_tvalid),
      .deg(26'($signed(req_tdata[23:0]))), .out_valid(sv0), .sin_q(sla), .cos_q(cla));
   gcda_sincos #(.STEPS(CORDIC_STEPS)) u_olon (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_tvalid),
      .deg($signed(req_tdata[49:24])), .out_valid(sv1), .sin_q(slo), .cos_q(clo));
   gcda_sincos #(.STEPS(CORDIC_STEPS)) u_tlat (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_tvalid),
      .deg(26'($signed(req_tdata[73:50]))), .out_valid(sv2), .sin_q(tsla), .cos_q(tcla));
   gcda_sincos #(.STEPS(CORDIC_STEPS)) u_tlon (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_tvalid),
      .deg($signed(req_tdata[99:74])), .out_valid(sv3), .sin_q(tslo), .cos_q(tclo));

   always_comb begin
      dc_in = d4_ff;
      if (d4_ff > ONE_Q30) begin
         dc_in = ONE_Q30;
      end else if (d4_ff < -ONE_Q30) begin
         dc_in = -ONE_Q30;
      end
      degen_in = (e6_ff <= DEGEN_TOL) && (e6_ff >= -DEGEN_TOL) &&
                 (nn6_ff <= DEGEN_TOL) && (nn6_ff >= -DEGEN_TOL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= sv0 & sv1 & sv2 & sv3;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pqx_ff <= cla * clo;
         pqy_ff <= cla * slo;
         ptx_ff <= tcla * tclo;
         pty_ff <= tcla * tslo;
         sla1_ff <= sla;
         cla1_ff <= cla;
         slo1_ff <= slo;
         clo1_ff <= clo;
         tz1_ff <= tsla;

         qx_ff <= rnd30(66'(pqx_ff));
         qy_ff <= rnd30(66'(pqy_ff));
         tx_ff <= rnd30(66'(ptx_ff));
         ty_ff <= rnd30(66'(pty_ff));
         sla2_ff <= sla1_ff;
         cla2_ff <= cla1_ff;
         slo2_ff <= slo1_ff;
         clo2_ff <= clo1_ff;
         tz2_ff <= tz1_ff;

         md0_ff <= qx_ff * tx_ff;
         md1_ff <= qy_ff * ty_ff;
         md2_ff <= sla2_ff * tz2_ff;
         me0_ff <= ty_ff * clo2_ff;
         me1_ff <= tx_ff * slo2_ff;
         mt0_ff <= tx_ff * clo2_ff;
         mt1_ff <= ty_ff * slo2_ff;
         sla3_ff <= sla2_ff;
         cla3_ff <= cla2_ff;
         tz3_ff <= tz2_ff;

         d4_ff <= rnd30(66'(md0_ff) + 66'(md1_ff) + 66'(md2_ff));
         e4_ff <= rnd30(66'(me0_ff) - 66'(me1_ff));
         t4_ff <= rnd30(66'(mt0_ff) + 66'(mt1_ff));
         sla4_ff <= sla3_ff;
         cla4_ff <= cla3_ff;
         tz4_ff <= tz3_ff;

         dc5_ff <= dc_in;
         dd5_ff <= dc_in * dc_in;
         mn0_ff <= cla4_ff * tz4_ff;
         mn1_ff <= sla4_ff * t4_ff;
         e5_ff <= e4_ff;

         rad6_ff <= 61'h1000000000000000 - dd5_ff[60:0];
         nn6_ff <= rnd30(66'(mn0_ff) - 66'(mn1_ff));
         dc6_ff <= dc5_ff;
         e6_ff <= e5_ff;
      end
   end

   gcda_isqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(v6_ff),
      .radicand(rad6_ff), .out_valid(sq_valid), .root(sq_root));

   gcda_delay #(.WIDTH(32), .DEPTH(31)) u_dly_dc (
      .clock(clock), .en(en), .d(dc6_ff), .q(dc_d));
   gcda_delay #(.WIDTH(32), .DEPTH(31)) u_dly_e (
      .clock(clock), .en(en), .d(e6_ff), .q(e_d));
   gcda_delay #(.WIDTH(32), .DEPTH(31)) u_dly_nn (
      .clock(clock), .en(en), .d(nn6_ff), .q(nn_d));
   gcda_delay #(.WIDTH(1), .DEPTH(32 + CORDIC_STEPS)) u_dly_dg (
      .clock(clock), .en(en), .d(degen_in), .q(degen_d));

   gcda_vec #(.STEPS(CORDIC_STEPS)) u_dist (
      .clock(clock), .reset(reset), .en(en), .in_valid(sq_valid),
      .y($signed(36'(sq_root))), .x(36'($signed(dc_d))), .out_valid(dv), .ang(zd));
   gcda_vec #(.STEPS(CORDIC_STEPS)) u_azim (
      .clock(clock), .reset(reset), .en(en), .in_valid(sq_valid),
      .y(36'($signed(e_d))), .x(36'($signed(nn_d))), .out_valid(av), .ang(za));

   always_comb begin
      dr = (zd + 34'sd512) >>> 10;
      if (dr < 0) begin
         dist_in = '0;
      end else if (dr > DIST_MAX) begin
         dist_in = 22'(DIST_MAX);
      end else begin
         dist_in = dr[21:0];
      end

      zw = 36'(za);
      if (zw < 0) begin
         zw = zw + TWO_PI;
      end
      ar = (zw + 36'sd512) >>> 10;
      if (degen_d[0] || ar < 0) begin
         az_in = '0;
      end else if (ar > AZ_MAX) begin
         az_in = 23'(AZ_MAX);
      end else begin
         az_in = ar[22:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= dv & av;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= dist_in;
         az_ff <= az_in;
         degen_ff <= degen_d[0];
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = {3'b000, az_ff, dist_ff};
   assign rsp_tuser = degen_ff;

endmodule

>>> sim/tb_great_circle_distance_azimuth.sv
// Testbench for the great-circle distance and azimuth block with a bit-exact predictor.
module tb_great_circle_distance_azimuth;
   import gcda_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEPS = 24;
   localparam longint DEG_FULL = 23592960;
   localparam longint DEG_HALF = 11796480;
   localparam longint DEG_QUARTER = 5898240;
   localparam longint RAD_PER_DEG_Q40 = 64'd19190098069;
   localparam longint GAIN_Q30 = 652032874;
   localparam longint TWO_PI_Q30 = 64'd6746518852;
   localparam longint ONE_Q30 = 64'd1073741824;
   localparam longint HALF_Q30 = 64'd536870912;
   localparam longint DIST_MAX = 3294199;
   localparam longint AZ_MAX = 6588397;
   localparam longint DEGEN_TOL = 32;
   localparam int N_RANDOM = 1250;

   typedef struct packed {
      logic [21:0] distance;
      logic [22:0] azimuth;
      logic        degenerate;
   } gc_result_t;

   function automatic longint round_q30(longint v);
      return (v + HALF_Q30) >>> 30;
   endfunction

   function automatic longint table_atan(int i);
      logic signed [33:0] a;
      a = atan_q30(i);
      return longint'(a);
   endfunction

   function automatic void cordic_sincos(longint deg, output longint s, output longint c);
      longint r, z, x, y, dx, dy, mag;
      bit flip;
      r = deg % DEG_FULL;
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      if (r < 0) r += DEG_FULL;
      if (r >= DEG_HALF) r -= DEG_FULL;
      if (r > DEG_QUARTER) begin
         r -= DEG_HALF;
         flip = 1;
      end else if (r < -DEG_QUARTER) begin
         r += DEG_HALF;
         flip = 1;
      end
      mag = (r < 0) ? -r : r;
      z = (mag * RAD_PER_DEG_Q40 + (64'd1 << 25)) >>> 26;
      if (r < 0) z = -z;
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= table_atan(i);
         end else begin
            x += dx; y -= dy; z += table_atan(i);
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      s = y;
      c = x;
   endfunction

   function automatic longint cordic_atan2(longint y, longint x);
      longint z, t, dx, dy;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = longint'(HALF_PI_Q30);
         end else begin
            t = x; x = -y; y = t; z = -longint'(HALF_PI_Q30);
         end
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += table_atan(i);
         end else begin
            x -= dx; y += dy; z -= table_atan(i);
         end
      end
      return z;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic gc_result_t predict_path(logic [103:0] w);
      longint sla, cla, slo, clo, tsla, tcla, tslo, tclo;
      longint qx, qy, tx, ty, d, h, dist_q, e, t, nn, az;
      gc_result_t r;
      cordic_sincos(longint'(signed'(w[23:0])), sla, cla);
      cordic_sincos(longint'(signed'(w[49:24])), slo, clo);
      cordic_sincos(longint'(signed'(w[73:50])), tsla, tcla);
      cordic_sincos(longint'(signed'(w[99:74])), tslo, tclo);
      qx = round_q30(cla * clo);
      qy = round_q30(cla * slo);
      tx = round_q30(tcla * tclo);
      ty = round_q30(tcla * tslo);
      d = round_q30(qx * tx + qy * ty + sla * tsla);
      if (d > ONE_Q30) d = ONE_Q30;
      if (d < -ONE_Q30) d = -ONE_Q30;
      h = int_sqrt(longint'(ONE_Q30 * ONE_Q30 - d * d));
      dist_q = (cordic_atan2(h, d) + 512) >>> 10;
      if (dist_q < 0) dist_q = 0;
      if (dist_q > DIST_MAX) dist_q = DIST_MAX;
      e = round_q30(-tx * slo + ty * clo);
      t = round_q30(tx * clo + ty * slo);
      nn = round_q30(-sla * t + cla * tsla);
      r.degenerate = (e <= DEGEN_TOL && e >= -DEGEN_TOL && nn <= DEGEN_TOL && nn >= -DEGEN_TOL);
      if (r.degenerate) begin
         az = 0;
      end else begin
         az = cordic_atan2(e, nn);
         if (az < 0) az += TWO_PI_Q30;
         az = (az + 512) >>> 10;
         if (az < 0) az = 0;
         if (az > AZ_MAX) az = AZ_MAX;
      end
      r.distance = dist_q[21:0];
      r.azimuth = az[22:0];
      return r;
   endfunction

   class path_scoreboard;
      gc_result_t pending[$];
      int errors;

      function void note_pair(logic [103:0] w);
         pending.push_back(predict_path(w));
      endfunction

      function void check_result(logic [47:0] data, logic deg);
         gc_result_t exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected word dist=%0d az=%0d degen=%0b", $realtime,
                     data[21:0], data[44:22], deg);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (data[21:0] !== exp_r.distance) begin
            $display("%0t: distance expected %0d actual %0d", $realtime, exp_r.distance,
                     data[21:0]);
            errors++;
         end
         if (data[44:22] !== exp_r.azimuth) begin
            $display("%0t: azimuth expected %0d actual %0d", $realtime, exp_r.azimuth,
                     data[44:22]);
            errors++;
         end
         if (deg !== exp_r.degenerate) begin
            $display("%0t: degenerate expected %0b actual %0b", $realtime, exp_r.degenerate,
                     deg);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [103:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic rsp_tuser;
   bit stim_done = 0;
   path_scoreboard sb = new();

   great_circle_distance_azimuth #(.CORDIC_STEPS(STEPS)) i_dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function automatic logic [103:0] pack_pair(longint olat, longint olon, longint tlat,
                                             longint tlon);
      return {4'd0, tlon[25:0], tlat[23:0], olon[25:0], olat[23:0]};
   endfunction

   task automatic send_pair(logic [103:0] w);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= w;
      do @(posedge clock); while (!req_tready);
      sb.note_pair(w);
      @(negedge clock);
   endtask

   function automatic longint rand_angle(int width, longint lim);
      case ($urandom_range(0, 7))
         0: return longint'(signed'(width == 24 ? 24'($urandom) : 26'($urandom)));
         1: return $urandom_range(0, 4) * (lim / 4) - lim;
         default: return longint'($urandom_range(0, 2 * lim)) - lim;
      endcase
   endfunction

   initial begin
      longint ol, oo, tl, to;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_pair(pack_pair(0, 0, 0, 0));
      send_pair(pack_pair(DEG_QUARTER, 0, -DEG_QUARTER, 0));
      send_pair(pack_pair(0, 0, 0, DEG_HALF));
      send_pair(pack_pair(-DEG_QUARTER, DEG_FULL, DEG_QUARTER, -DEG_FULL));
      send_pair(pack_pair(DEG_QUARTER, 12345, DEG_QUARTER, -999999));
      send_pair(pack_pair(0, 0, 65536, 0));
      send_pair(pack_pair(0, 0, 0, 65536));
      send_pair(pack_pair(0, 0, -65536, 0));
      send_pair(pack_pair(0, 0, 0, -65536));
      send_pair(pack_pair(0, 0, 0, 1));
      send_pair(pack_pair(2949120, 655360, -2949120, 655360 + DEG_HALF));
      send_pair(pack_pair(-24'sd8388608, -26'sd33554432, 24'sd8388607, 26'sd33554431));
      send_pair(pack_pair(24'sd8388607, 26'sd33554431, -24'sd8388608, -26'sd33554432));
      send_pair(pack_pair(DEG_QUARTER + 65536, 0, 0, 0));
      send_pair(pack_pair(123456, 7654321, 123456, 7654321 + DEG_FULL));
      for (int n = 0; n < N_RANDOM; n++) begin
         ol = rand_angle(24, DEG_QUARTER);
         oo = rand_angle(26, DEG_FULL);
         if ($urandom_range(0, 15) == 0) begin
            tl = ol; to = oo;
         end else if ($urandom_range(0, 15) == 0) begin
            tl = -ol; to = oo + DEG_HALF;
         end else if ($urandom_range(0, 7) == 0) begin
            tl = ol + $urandom_range(0, 64) - 32; to = oo + $urandom_range(0, 64) - 32;
         end else begin
            tl = rand_angle(24, DEG_QUARTER); to = rand_angle(26, DEG_FULL);
         end
         send_pair(pack_pair(ol, oo, tl, to));
      end
      req_tvalid <= 0;
      stim_done = 1;
   end

   initial begin
      int gap;
      @(negedge clock);
      forever begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   initial begin
      wait (stim_done);
      wait (sb.pending.size() == 0);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("FAILURE");
      $finish;
   end
endmodule

>>> sim.f
src/gcda_pkg.sv
src/gcda_delay.sv
src/gcda_sincos.sv
src/gcda_isqrt.sv
src/gcda_vec.sv
src/great_circle_distance_azimuth.sv
sim/tb_great_circle_distance_azimuth.sv
